FILE: hdl/lfcr_pkg.sv
// Shared types, status codes and CRC-16/MODBUS byte update for the frame receiver.
package lfcr_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  MIN_LEN  = 8'd4;

  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_OK      = 3'd1,
    ST_CRC_ERR = 3'd2,
    ST_EXCEPT  = 3'd3,
    ST_SHORT   = 3'd4,
    ST_BAD_LEN = 3'd5
  } status_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] out_byte;
    logic [7:0] byte_index;
    logic       is_last;
    status_t    status;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

FILE: hdl/lfcr_frame.sv
// Frame state and per-byte decode: address hunt, length, exception and CRC check.
module lfcr_frame
  import lfcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  rx_byte,
  input  logic        line_gap,
  input  logic [7:0]  station_addr,
  output result_t     res
);

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  trail_r, trail_nxt;
  logic        exc_r, exc_nxt;
  logic        go_hunt;
  logic [8:0]  idx_p1;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    trail_nxt = trail_r;
    exc_nxt   = exc_r;
    go_hunt   = 1'b0;
    res       = '0;
    idx_p1    = {1'b0, count_r} + 9'd1;

    if (line_gap) begin
      if (phase_r == PH_LENGTH || phase_r == PH_BODY) begin
        res     = '{1'b1, 8'h00, count_r, 1'b1, ST_SHORT};
        go_hunt = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_LENGTH: begin
          if (rx_byte < MIN_LEN) begin
            res     = '{1'b1, rx_byte, 8'd1, 1'b1, ST_BAD_LEN};
            go_hunt = 1'b1;
          end else begin
            len_nxt   = rx_byte;
            crc_nxt   = crc_byte(crc_r, rx_byte);
            count_nxt = 8'd2;
            phase_nxt = PH_BODY;
            res       = '{1'b1, rx_byte, 8'd1, 1'b0, ST_DATA};
          end
        end
        PH_BODY: begin
          if (exc_r) begin
            res     = '{1'b1, rx_byte, count_r, 1'b1, ST_EXCEPT};
            go_hunt = 1'b1;
          end else if (count_r == 8'd2 && rx_byte[7]) begin
            exc_nxt   = 1'b1;
            count_nxt = idx_p1[7:0];
            res       = '{1'b1, rx_byte, count_r, 1'b0, ST_DATA};
          end else if (idx_p1 >= {1'b0, len_r}) begin
            res     = '{1'b1, rx_byte, count_r, 1'b1,
                        ({rx_byte, trail_r} == crc_r) ? ST_OK : ST_CRC_ERR};
            go_hunt = 1'b1;
          end else begin
            if (idx_p1 + 9'd1 == {1'b0, len_r}) trail_nxt = rx_byte;
            else                                crc_nxt   = crc_byte(crc_r, rx_byte);
            count_nxt = idx_p1[7:0];
            res       = '{1'b1, rx_byte, count_r, 1'b0, ST_DATA};
          end
        end
        default: begin
          // hunting, and any unused phase code
          if (rx_byte == station_addr) begin
            exc_nxt   = 1'b0;
            len_nxt   = 8'd0;
            trail_nxt = 8'd0;
            crc_nxt   = crc_byte(CRC_INIT, rx_byte);
            count_nxt = 8'd1;
            phase_nxt = PH_LENGTH;
            res       = '{1'b1, rx_byte, 8'd0, 1'b0, ST_DATA};
          end else begin
            go_hunt = 1'b1;
          end
        end
      endcase
    end

    if (go_hunt) begin
      phase_nxt = PH_HUNT;
      count_nxt = 8'd0;
      len_nxt   = 8'd0;
      crc_nxt   = CRC_INIT;
      trail_nxt = 8'd0;
      exc_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= 8'd0;
      len_r   <= 8'd0;
      crc_r   <= CRC_INIT;
      trail_r <= 8'd0;
      exc_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      trail_r <= trail_nxt;
      exc_r   <= exc_nxt;
    end
  end

endmodule

FILE: hdl/length_framed_crc16_receiver.sv
// Top level of the length-framed CRC-16/MODBUS frame receiver.
//
//   channel | dir | tdata                         | tuser      | tlast
//   in_     | in  | [7:0] rx_byte                 | line_gap   | -
//   out_    | out | [7:0] out_byte, [15:8] index  | [2:0] status | is_last
//   cfg_    | in  | [7:0] station_address (write enable, no read-back)
//
// One input transfer per cycle sustained while the result side is not stalled; each
// transfer passes the input register, then decode/CRC into the result register.
// Synchronous active-low reset; station address resets to 1.
// A stalled result register stalls the input stage; nothing is lost.
module length_framed_crc16_receiver
  import lfcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] line_gap
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [15:8] byte_index
  output logic        out_tlast,  // is_last
  output logic [2:0]  out_tuser,  // [2:0] status
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_gap_r;
  logic [7:0]  addr_r;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_last_r;
  logic [2:0]  out_status_r;
  logic        out_free;
  logic        step;
  result_t     res;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  lfcr_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step),
    .rx_byte      (s1_byte_r),
    .line_gap     (s1_gap_r),
    .station_addr (addr_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= 8'd1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) addr_r <= cfg_wr_data;
      if (in_tready) s1_valid_r <= in_tvalid;
      if (out_free)  out_valid_r <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_gap_r  <= in_tuser;
    end
    if (step && res.emit) begin
      out_data_r   <= {res.byte_index, res.out_byte};
      out_last_r   <= res.is_last;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

endmodule

FILE: hdl/lfcr_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
module lfcr_checker
  import lfcr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic [2:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == ST_DATA) == !out_tlast))
    else $error("tlast disagrees with status");

  a_addr_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:8] == 8'd0 |-> out_tuser == ST_DATA)
    else $error("frame end reported at address byte");

  a_crc_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OK || out_tuser == ST_CRC_ERR)
      |-> out_tdata[15:8] >= 8'd3)
    else $error("crc result before minimum frame length");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_BAD_LEN)
    else $error("undefined status code");

endmodule

bind length_framed_crc16_receiver lfcr_checker u_lfcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
